// ===== src/calendar_date_counter_macros.svh =====
// Assertion macros for the calendar date counter checker.
// Include-only header; no dependencies.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// Clocked assertion, ignored while reset is held
`define CDC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also applies during reset
`define CDC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== src/cdc_pkg.sv =====
// Shared types, constants and calendar helper functions for the date counter.
// No dependencies.
package cdc_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_DIFF = 2'd3
  } op_t;

  // Widest year the stored year register can hold
  localparam int unsigned YEAR_MAX = 16383;

  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [13:0] RESET_YEAR  = 14'd1930;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  LAST_DEC  = 5'd31;
  localparam logic [4:0]  LEAP_FEB  = 5'd29;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days before the first of each month in a common year (index = month)
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  // floor(q / 25) = (q * 5243) >> 17, exact for q below 43690
  localparam logic [12:0] RECIP25 = 13'd5243;

  // Checked input item
  typedef struct packed {
    op_t         op;
    logic [5:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        leap;
    logic        d_ok;
    logic        m_ok;
    logic        y_ok;
  } chk_t;

  // Executed item: date after the operation plus the difference operand
  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic        day_rej;
    logic        month_rej;
    logic        year_rej;
    logic        range_hit;
    logic        diff_en;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic        in_leap;
  } exe_t;

  // Day counts split into year base and day of year
  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic        day_rej;
    logic        month_rej;
    logic        year_rej;
    logic        range_hit;
    logic        diff_en;
    logic [22:0] base_a;
    logic [22:0] base_b;
    logic [8:0]  doy_a;
    logic [8:0]  doy_b;
  } cnt_t;

  // Finished result
  typedef struct packed {
    logic [4:0]         cur_day;
    logic [3:0]         cur_month;
    logic [13:0]        cur_year;
    logic signed [23:0] day_diff;
    logic               day_rej;
    logic               month_rej;
    logic               year_rej;
    logic               range_hit;
  } res_t;

  function automatic logic [9:0] div25(input logic [13:0] q);
    logic [26:0] prod;
    prod = {13'b0, q} * {14'b0, RECIP25};
    return prod[26:17];
  endfunction

  // Divisible by 4 and not by 100, or divisible by 400
  function automatic logic is_leap(input logic [15:0] y);
    logic [13:0] q;
    logic [13:0] back;
    q    = y[15:2];
    back = {4'b0, div25(q)} * 14'd25;
    return (y[1:0] == 2'b00) && ((q != back) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m < MONTH_JAN || m > MONTH_DEC) begin
      return 5'd0;
    end
    if (m == MONTH_FEB && lp) begin
      return LEAP_FEB;
    end
    return MONTH_LEN[idx];
  endfunction

  // Days from Jan 1 of year 0 to Jan 1 of year y
  function automatic logic [22:0] year_base(input logic [13:0] y);
    logic [14:0] y3;
    logic [14:0] y99;
    logic [14:0] y399;
    logic [22:0] t;
    y3   = {1'b0, y} + 15'd3;
    y99  = {1'b0, y} + 15'd99;
    y399 = {1'b0, y} + 15'd399;
    t = {9'b0, y} * 23'd365;
    t = t + {10'b0, y3[14:2]}
          - {13'b0, div25({1'b0, y99[14:2]})}
          + {13'b0, div25({3'b0, y399[14:4]})};
    return t;
  endfunction

  // Zero-based day within the year
  function automatic logic [8:0] day_of_year(input logic [3:0] m, input logic [4:0] d,
                                             input logic lp);
    logic adj;
    adj = (m > MONTH_FEB) && lp;
    return CUM_DAYS[m] + {8'b0, adj} + {4'b0, d} - 9'd1;
  endfunction

endpackage

// ===== src/cdc_check.sv =====
// Input register and operand check stage of the date counter.
// Depends on cdc_pkg.
module cdc_check #(
  parameter int unsigned YEAR_TOP = 16383
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdc_pkg::op_t       in_op,
  input  logic [5:0]         in_day,
  input  logic [3:0]         in_month,
  input  logic signed [15:0] in_year,
  output logic               chk_valid,
  output cdc_pkg::chk_t      chk,
  input  logic               chk_ready
);

  logic               s0_valid_r;
  cdc_pkg::op_t       s0_op_r;
  logic [5:0]         s0_day_r;
  logic [3:0]         s0_month_r;
  logic signed [15:0] s0_year_r;
  logic               chk_valid_r;
  cdc_pkg::chk_t      chk_r;
  cdc_pkg::chk_t      chk_nxt;

  logic       s0_adv;
  logic       s1_adv;
  logic [15:0] yabs;
  logic        leap;
  logic [4:0]  dim;
  logic        m_ok;

  // Advance a stage when it is empty or its content moves on
  assign s1_adv   = !chk_valid_r || chk_ready;
  assign s0_adv   = !s0_valid_r || s1_adv;
  assign in_ready = s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      chk_valid_r <= 1'b0;
    end else begin
      if (s0_adv) begin
        s0_valid_r <= in_valid;
      end
      if (s1_adv) begin
        chk_valid_r <= s0_valid_r;
      end
    end
  end

  // Capture operands on each transfer
  always_ff @(posedge clk) begin
    if (s0_adv && in_valid) begin
      s0_op_r    <= in_op;
      s0_day_r   <= in_day;
      s0_month_r <= in_month;
      s0_year_r  <= in_year;
    end
    if (s1_adv && s0_valid_r) begin
      chk_r <= chk_nxt;
    end
  end

  // Validate day, month and year; a negative year takes leap status from its magnitude
  always_comb begin
    yabs = s0_year_r[15] ? (~s0_year_r + 16'd1) : s0_year_r;
    leap = cdc_pkg::is_leap(yabs);
    dim  = cdc_pkg::days_in(s0_month_r, leap);
    m_ok = (s0_month_r >= cdc_pkg::MONTH_JAN) && (s0_month_r <= cdc_pkg::MONTH_DEC);

    chk_nxt.op    = s0_op_r;
    chk_nxt.day   = s0_day_r;
    chk_nxt.month = s0_month_r;
    chk_nxt.year  = s0_year_r[13:0];
    chk_nxt.leap  = leap;
    chk_nxt.m_ok  = m_ok;
    chk_nxt.d_ok  = m_ok && (s0_day_r != 6'd0) && (s0_day_r <= {1'b0, dim});
    chk_nxt.y_ok  = !s0_year_r[15] && (s0_year_r[14:0] <= 15'(YEAR_TOP));
  end

  assign chk_valid = chk_valid_r;
  assign chk       = chk_r;

endmodule

// ===== src/cdc_exec.sv =====
// Execute stage: holds the stored date and applies set, step or difference.
// Depends on cdc_pkg.
module cdc_exec #(
  parameter int unsigned YEAR_TOP = 16383
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          chk_valid,
  input  cdc_pkg::chk_t chk,
  output logic          chk_ready,
  output logic          exe_valid,
  output cdc_pkg::exe_t exe,
  input  logic          exe_ready
);

  logic [4:0]    day_r;
  logic [3:0]    month_r;
  logic [13:0]   year_r;
  logic [4:0]    day_nxt;
  logic [3:0]    month_nxt;
  logic [13:0]   year_nxt;
  logic          exe_valid_r;
  cdc_pkg::exe_t exe_r;
  cdc_pkg::exe_t exe_nxt;

  logic       adv;
  logic       take;
  logic       leap_s;
  logic [4:0] dim;
  logic [4:0] dim_prev;
  logic       rej_en;
  logic       hit;
  logic       diff_en;

  assign adv       = !exe_valid_r || exe_ready;
  assign chk_ready = adv;
  assign take      = chk_valid && adv;

  // Month lengths of the stored date and of the month before it
  always_comb begin
    leap_s   = cdc_pkg::is_leap({2'b0, year_r});
    dim      = cdc_pkg::days_in(month_r, leap_s);
    dim_prev = cdc_pkg::days_in(month_r - 4'd1, leap_s);
  end

  // Apply the operation to the stored date
  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rej_en    = 1'b0;
    hit       = 1'b0;
    diff_en   = 1'b0;
    unique case (chk.op)
      cdc_pkg::OP_SET: begin
        rej_en = 1'b1;
        if (chk.d_ok) begin
          day_nxt = chk.day[4:0];
        end
        if (chk.m_ok) begin
          month_nxt = chk.month;
        end
        if (chk.y_ok) begin
          year_nxt = chk.year;
        end
      end
      cdc_pkg::OP_INC: begin
        if (day_r >= dim) begin
          if (month_r >= cdc_pkg::MONTH_DEC) begin
            if (year_r >= 14'(YEAR_TOP)) begin
              hit = 1'b1;
            end else begin
              year_nxt  = year_r + 14'd1;
              month_nxt = cdc_pkg::MONTH_JAN;
              day_nxt   = 5'd1;
            end
          end else begin
            month_nxt = month_r + 4'd1;
            day_nxt   = 5'd1;
          end
        end else begin
          day_nxt = day_r + 5'd1;
        end
      end
      cdc_pkg::OP_DEC: begin
        if (day_r <= 5'd1) begin
          if (month_r <= cdc_pkg::MONTH_JAN) begin
            if (year_r == 14'd0) begin
              hit = 1'b1;
            end else begin
              year_nxt  = year_r - 14'd1;
              month_nxt = cdc_pkg::MONTH_DEC;
              day_nxt   = cdc_pkg::LAST_DEC;
            end
          end else begin
            month_nxt = month_r - 4'd1;
            day_nxt   = dim_prev;
          end
        end else begin
          day_nxt = day_r - 5'd1;
        end
      end
      cdc_pkg::OP_DIFF: begin
        rej_en  = 1'b1;
        diff_en = chk.d_ok && chk.m_ok && chk.y_ok;
      end
    endcase
  end

  // Result snapshot: date after the operation plus difference operand
  always_comb begin
    exe_nxt.cur_day   = day_nxt;
    exe_nxt.cur_month = month_nxt;
    exe_nxt.cur_year  = year_nxt;
    exe_nxt.day_rej   = rej_en && !chk.d_ok;
    exe_nxt.month_rej = rej_en && !chk.m_ok;
    exe_nxt.year_rej  = rej_en && !chk.y_ok;
    exe_nxt.range_hit = hit;
    exe_nxt.diff_en   = diff_en;
    exe_nxt.in_day    = chk.day[4:0];
    exe_nxt.in_month  = chk.month;
    exe_nxt.in_year   = chk.year;
    exe_nxt.in_leap   = chk.leap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r       <= cdc_pkg::RESET_DAY;
      month_r     <= cdc_pkg::RESET_MONTH;
      year_r      <= cdc_pkg::RESET_YEAR;
      exe_valid_r <= 1'b0;
    end else begin
      if (take) begin
        day_r   <= day_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
      end
      if (adv) begin
        exe_valid_r <= chk_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      exe_r <= exe_nxt;
    end
  end

  assign exe_valid = exe_valid_r;
  assign exe       = exe_r;

endmodule

// ===== src/cdc_count.sv =====
// Day-count stage and output register: turns both dates into day numbers
// and subtracts them. Depends on cdc_pkg.
module cdc_count (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          exe_valid,
  input  cdc_pkg::exe_t exe,
  output logic          exe_ready,
  output logic          res_valid,
  output cdc_pkg::res_t res,
  input  logic          res_ready
);

  logic          cnt_valid_r;
  cdc_pkg::cnt_t cnt_r;
  cdc_pkg::cnt_t cnt_nxt;
  logic          res_valid_r;
  cdc_pkg::res_t res_r;
  cdc_pkg::res_t res_nxt;

  logic        s3_adv;
  logic        s4_adv;
  logic [22:0] cnt_a;
  logic [22:0] cnt_b;
  logic [23:0] diff;

  assign s4_adv    = !res_valid_r || res_ready;
  assign s3_adv    = !cnt_valid_r || s4_adv;
  assign exe_ready = s3_adv;

  // Year base and day of year for stored and input dates
  always_comb begin
    cnt_nxt.cur_day   = exe.cur_day;
    cnt_nxt.cur_month = exe.cur_month;
    cnt_nxt.cur_year  = exe.cur_year;
    cnt_nxt.day_rej   = exe.day_rej;
    cnt_nxt.month_rej = exe.month_rej;
    cnt_nxt.year_rej  = exe.year_rej;
    cnt_nxt.range_hit = exe.range_hit;
    cnt_nxt.diff_en   = exe.diff_en;
    cnt_nxt.base_a    = cdc_pkg::year_base(exe.cur_year);
    cnt_nxt.base_b    = cdc_pkg::year_base(exe.in_year);
    cnt_nxt.doy_a     = cdc_pkg::day_of_year(exe.cur_month, exe.cur_day,
                                             cdc_pkg::is_leap({2'b0, exe.cur_year}));
    cnt_nxt.doy_b     = cdc_pkg::day_of_year(exe.in_month, exe.in_day, exe.in_leap);
  end

  // Stored minus input day number; zero unless a difference operation's operands all passed
  always_comb begin
    cnt_a = cnt_r.base_a + {14'b0, cnt_r.doy_a};
    cnt_b = cnt_r.base_b + {14'b0, cnt_r.doy_b};
    diff  = {1'b0, cnt_a} - {1'b0, cnt_b};

    res_nxt.cur_day   = cnt_r.cur_day;
    res_nxt.cur_month = cnt_r.cur_month;
    res_nxt.cur_year  = cnt_r.cur_year;
    res_nxt.day_diff  = cnt_r.diff_en ? $signed(diff) : 24'sd0;
    res_nxt.day_rej   = cnt_r.day_rej;
    res_nxt.month_rej = cnt_r.month_rej;
    res_nxt.year_rej  = cnt_r.year_rej;
    res_nxt.range_hit = cnt_r.range_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (s3_adv) begin
        cnt_valid_r <= exe_valid;
      end
      if (s4_adv) begin
        res_valid_r <= cnt_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && exe_valid) begin
      cnt_r <= cnt_nxt;
    end
    if (s4_adv && cnt_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== src/calendar_date_counter.sv =====
// Gregorian calendar date counter: holds a date and applies set, next day,
// previous day or difference, one operation per stream transfer. Each
// operation returns one result with the stored date after it, the day
// difference (stored minus input, zero unless a difference operation had
// every operand valid) and the operand and range flags. The block takes
// one item every clock cycle while the result side is not stalled. Each
// result passes an input register, an operand check stage, the execute
// stage holding the stored date, a day count stage and the output register.
// Backpressure on the result side fills the stages before the input
// stalls. After reset the date is January 1, 1930, with no start-up delay.
// Depends on cdc_pkg, cdc_check, cdc_exec and cdc_count.
module calendar_date_counter #(
  parameter int unsigned YEAR_LIMIT = 16383
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_day[5:0], in_month[9:6], in_year[25:10], zero
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                  // day_diff[46:23], day_rejected[47],
                                  // month_rejected[48], year_rejected[49],
                                  // range_hit[50], zero
);

  localparam int unsigned YearTop =
    (YEAR_LIMIT < cdc_pkg::YEAR_MAX) ? YEAR_LIMIT : cdc_pkg::YEAR_MAX;

  logic          chk_valid;
  logic          chk_ready;
  cdc_pkg::chk_t chk;
  logic          exe_valid;
  logic          exe_ready;
  cdc_pkg::exe_t exe;
  cdc_pkg::res_t res;

  cdc_check #(
    .YEAR_TOP (YearTop)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (cdc_pkg::op_t'(in_tuser)),
    .in_day    (in_tdata[5:0]),
    .in_month  (in_tdata[9:6]),
    .in_year   ($signed(in_tdata[25:10])),
    .chk_valid (chk_valid),
    .chk       (chk),
    .chk_ready (chk_ready)
  );

  cdc_exec #(
    .YEAR_TOP (YearTop)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .chk_valid (chk_valid),
    .chk       (chk),
    .chk_ready (chk_ready),
    .exe_valid (exe_valid),
    .exe       (exe),
    .exe_ready (exe_ready)
  );

  cdc_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .exe_valid (exe_valid),
    .exe       (exe),
    .exe_ready (exe_ready),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // Pack the result, first field in the low bits
  assign out_tdata = {5'b0, res.range_hit, res.year_rej, res.month_rej, res.day_rej,
                      res.day_diff, res.cur_year, res.cur_month, res.cur_day};

endmodule

// ===== src/cdc_checker.sv =====
// Port-level checks for the calendar date counter, bound to the top level.
// Depends on calendar_date_counter_macros.svh.
`include "calendar_date_counter_macros.svh"

module cdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // A stalled result holds
  `CDC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // No result right after reset
  `CDC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // Stored date stays a real month and a nonzero day
  `CDC_ASSERT(a_date_range, clk, rst_n, out_tvalid |-> out_tdata[8:5] != 4'd0 && out_tdata[8:5] <= 4'd12 && out_tdata[4:0] != 5'd0, "stored date out of range")

  // Range flag only on steps, operand flags only on set and difference
  `CDC_ASSERT(a_flag_excl, clk, rst_n, out_tvalid && out_tdata[50] |-> !out_tdata[47] && !out_tdata[48] && !out_tdata[49], "range flag with operand flag")

  // A rejected operand gives no difference
  `CDC_ASSERT(a_diff_zero, clk, rst_n, out_tvalid && (out_tdata[47] || out_tdata[48] || out_tdata[49]) |-> out_tdata[46:23] == 24'd0, "difference on rejected operand")

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb_calendar_date_counter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_counter: drives set, next day,
// previous day and difference operations, predicts every result in step.
// Depends on cdc_pkg and calendar_date_counter.
module tb_calendar_date_counter;

  localparam int unsigned YEAR_LIMIT  = 16383;
  localparam int unsigned YEAR_TOP    =
    (YEAR_LIMIT < cdc_pkg::YEAR_MAX) ? YEAR_LIMIT : cdc_pkg::YEAR_MAX;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int unsigned COMMON_MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                     31, 31, 30, 31, 30, 31};

  // Receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  // Expected contents of one result transfer
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [23:0] diff;
    logic        day_rej;
    logic        month_rej;
    logic        year_rej;
    logic        range_hit;
  } date_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // in_day[5:0], in_month[9:6], in_year[25:10], zero
  logic [1:0]  in_tuser   = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                  // day_diff[46:23], day_rejected[47],
                                  // month_rejected[48], year_rejected[49],
                                  // range_hit[50], zero

  // Predicted stored date
  int unsigned  cal_day   = cdc_pkg::RESET_DAY;
  int unsigned  cal_month = cdc_pkg::RESET_MONTH;
  int unsigned  cal_year  = cdc_pkg::RESET_YEAR;

  date_result_t expected_dates [$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;

  // Receiver stall controls
  int rx_mode      = RX_ALWAYS;
  int rx_ready_pct = 50;
  int rx_period    = 4;
  int rx_on_cycles = 2;
  int rx_phase     = 0;
  int hold_left    = 0;

  calendar_date_counter #(
    .YEAR_LIMIT(YEAR_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive out_tready: long hold-off first, then the selected stall pattern
  always @(posedge clk) begin
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:   out_tready <= ($urandom_range(0, 99) < rx_ready_pct);
        RX_PERIODIC: out_tready <= ((rx_phase % rx_period) < rx_on_cycles);
        default:     out_tready <= 1'b1;
      endcase
    end
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) begin
      return 0;
    end
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return COMMON_MONTH_DAYS[m - 1];
  endfunction

  // Days since Jan 1 of year 0, proleptic Gregorian
  function automatic int days_from_epoch(int unsigned d, int unsigned m, int unsigned y);
    int unsigned t;
    t = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned i = 1; i < m && i <= 12; i++) begin
      t += COMMON_MONTH_DAYS[i - 1];
    end
    if (m > 2 && leap_year(y)) begin
      t++;
    end
    t += d - 1;
    return int'(t);
  endfunction

  // Apply one operation to the predicted date and return the expected result
  function automatic date_result_t step_calendar(cdc_pkg::op_t op, logic [5:0] d_in,
                                                 logic [3:0] m_in, logic [15:0] y_in);
    int           y_s;
    int unsigned  y_abs;
    bit           m_ok;
    bit           d_ok;
    bit           y_ok;
    int           diff;
    date_result_t r;
    y_s   = int'($signed(y_in));
    y_abs = (y_s < 0) ? -y_s : y_s;
    m_ok  = (m_in >= 1) && (m_in <= 12);
    d_ok  = m_ok && (d_in >= 1) && (d_in <= month_days(32'(m_in), y_abs));
    y_ok  = (y_s >= 0) && (y_s <= int'(YEAR_TOP));
    diff  = 0;
    r     = '0;
    if (op == cdc_pkg::OP_SET || op == cdc_pkg::OP_DIFF) begin
      r.day_rej   = !d_ok;
      r.month_rej = !m_ok;
      r.year_rej  = !y_ok;
    end
    case (op)
      cdc_pkg::OP_SET: begin
        if (d_ok) cal_day = 32'(d_in);
        if (m_ok) cal_month = 32'(m_in);
        if (y_ok) cal_year = y_s;
      end
      cdc_pkg::OP_INC: begin
        if (cal_day >= month_days(cal_month, cal_year)) begin
          if (cal_month >= 12) begin
            if (cal_year >= YEAR_TOP) begin
              r.range_hit = 1'b1;
            end else begin
              cal_year++;
              cal_month = 1;
              cal_day   = 1;
            end
          end else begin
            cal_month++;
            cal_day = 1;
          end
        end else begin
          cal_day++;
        end
      end
      cdc_pkg::OP_DEC: begin
        if (cal_day <= 1) begin
          if (cal_month <= 1) begin
            if (cal_year == 0) begin
              r.range_hit = 1'b1;
            end else begin
              cal_year--;
              cal_month = 12;
              cal_day   = 31;
            end
          end else begin
            cal_month--;
            cal_day = month_days(cal_month, cal_year);
          end
        end else begin
          cal_day--;
        end
      end
      default: begin
        if (d_ok && m_ok && y_ok) begin
          diff = days_from_epoch(cal_day, cal_month, cal_year) -
                 days_from_epoch(32'(d_in), 32'(m_in), y_s);
        end
      end
    endcase
    r.day   = cal_day[4:0];
    r.month = cal_month[3:0];
    r.year  = cal_year[13:0];
    r.diff  = diff[23:0];
    return r;
  endfunction

  // Offer one item and hold it until the transfer; tvalid stays high afterwards
  task automatic send_item(cdc_pkg::op_t op, logic [5:0] d, logic [3:0] m,
                           logic [15:0] y);
    logic ready;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, y, m, d};
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
    expected_dates.push_back(step_calendar(op, d, m, y));
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_dates.size() != 0);
  endtask

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Check each result transfer against the oldest prediction
  always @(negedge clk) begin
    date_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_dates.size() == 0) begin
        $error("result transfer with no prediction pending: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("cur_day", want.day, out_tdata[4:0]);
        check_field("cur_month", want.month, out_tdata[8:5]);
        check_field("cur_year", want.year, out_tdata[22:9]);
        check_field("day_diff", $signed(want.diff), $signed(out_tdata[46:23]));
        check_field("day_rejected", want.day_rej, out_tdata[47]);
        check_field("month_rejected", want.month_rej, out_tdata[48]);
        check_field("year_rejected", want.year_rej, out_tdata[49]);
        check_field("range_hit", want.range_hit, out_tdata[50]);
      end
    end
  end

  task automatic random_year(output logic [15:0] y);
    case ($urandom_range(0, 5))
      0, 1: y = 16'($urandom_range(0, YEAR_TOP));
      2:    y = 16'($urandom_range(0, 3));
      3:    y = 16'(YEAR_TOP - $urandom_range(0, 3));
      4:    y = 16'(100 * $urandom_range(0, YEAR_TOP / 100));
      default: y = 16'($urandom_range(1800, 2100));
    endcase
  endtask

  // Mostly well-formed operations, some with one broken operand, some noise
  task automatic random_item(output cdc_pkg::op_t op, output logic [5:0] d,
                             output logic [3:0] m, output logic [15:0] y);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op = cdc_pkg::op_t'($urandom_range(0, 3));
      d  = 6'($urandom_range(0, 63));
      m  = 4'($urandom_range(0, 15));
      y  = 16'($urandom_range(0, 65535));
    end else begin
      op = (pick < 26) ? cdc_pkg::OP_SET :
           (pick < 60) ? cdc_pkg::OP_INC :
           (pick < 88) ? cdc_pkg::OP_DEC : cdc_pkg::OP_DIFF;
      random_year(y);
      m = 4'($urandom_range(1, 12));
      d = 6'($urandom_range(1, month_days(32'(m), 32'(y))));
      // Park at a range end so the following steps can run into it
      if (op == cdc_pkg::OP_SET && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) begin
          d = {1'b0, cdc_pkg::LAST_DEC};
          m = cdc_pkg::MONTH_DEC;
          y = 16'(YEAR_TOP);
        end else begin
          d = 6'd1;
          m = cdc_pkg::MONTH_JAN;
          y = 16'd0;
        end
      end
      if ((op == cdc_pkg::OP_SET || op == cdc_pkg::OP_DIFF) &&
          $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: d = $urandom_range(0, 1) ? 6'd0
                 : 6'($urandom_range(month_days(32'(m), 32'(y)) + 1, 63));
          1: m = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
          default: y = $urandom_range(0, 1) ? 16'(-int'($urandom_range(1, 32768)))
                                            : 16'($urandom_range(YEAR_TOP + 1, 32767));
        endcase
      end
    end
  endtask

  // Difference against the reset date itself
  task automatic test_reset_date();
    send_item(cdc_pkg::OP_DIFF, 6'd1, 4'd1, 16'd1930);
  endtask

  // Next day past the top year and previous day before year 0 both hold
  task automatic test_range_ends();
    send_item(cdc_pkg::OP_SET, 6'd31, 4'd12, 16'(YEAR_TOP));
    send_item(cdc_pkg::OP_INC, 6'd0, 4'd0, 16'd0);
    send_item(cdc_pkg::OP_DEC, 6'd0, 4'd0, 16'd0);
    send_item(cdc_pkg::OP_SET, 6'd1, 4'd1, 16'd0);
    send_item(cdc_pkg::OP_DEC, 6'd0, 4'd0, 16'd0);
    send_item(cdc_pkg::OP_INC, 6'd0, 4'd0, 16'd0);
  endtask

  // Leap rules, month rollover both ways, and a partly loaded Feb 29
  task automatic test_leap_rollover();
    send_item(cdc_pkg::OP_SET, 6'd29, 4'd2, 16'd2000);
    send_item(cdc_pkg::OP_INC, 6'd0, 4'd0, 16'd0);
    send_item(cdc_pkg::OP_DEC, 6'd0, 4'd0, 16'd0);
    send_item(cdc_pkg::OP_SET, 6'd29, 4'd2, 16'd1900);
    send_item(cdc_pkg::OP_SET, 6'd1, 4'd3, 16'd1900);
    send_item(cdc_pkg::OP_DEC, 6'd0, 4'd0, 16'd0);
    send_item(cdc_pkg::OP_SET, 6'd29, 4'd1, 16'd2001);
    send_item(cdc_pkg::OP_SET, 6'd0, 4'd2, 16'd2001);
    send_item(cdc_pkg::OP_INC, 6'd0, 4'd0, 16'd0);
  endtask

  // Operand extremes: all-ones day, bad months, negative and oversized years
  task automatic test_operand_checks();
    send_item(cdc_pkg::OP_SET, 6'd63, 4'd15, 16'h8000);
    send_item(cdc_pkg::OP_SET, 6'd29, 4'd2, 16'hFFFC);
    send_item(cdc_pkg::OP_SET, 6'd0, 4'd0, 16'(YEAR_TOP + 1));
    send_item(cdc_pkg::OP_DIFF, 6'd31, 4'd12, 16'hFFFF);
  endtask

  // Largest negative and positive differences
  task automatic test_difference();
    send_item(cdc_pkg::OP_SET, 6'd1, 4'd1, 16'd0);
    send_item(cdc_pkg::OP_DIFF, 6'd31, 4'd12, 16'(YEAR_TOP));
    send_item(cdc_pkg::OP_SET, 6'd31, 4'd12, 16'(YEAR_TOP));
    send_item(cdc_pkg::OP_DIFF, 6'd1, 4'd1, 16'd0);
  endtask

  // Receiver holds off long enough that the pipeline fills and stalls the input
  task automatic test_backpressure(int count);
    cdc_pkg::op_t op;
    logic [5:0]   d;
    logic [3:0]   m;
    logic [15:0]  y;
    rx_mode   = RX_ALWAYS;
    hold_left = 250;
    repeat (count) begin
      random_item(op, d, m, y);
      send_item(op, d, m, y);
    end
  endtask

  // Sender pauses until everything in flight has come out
  task automatic test_drain_pause(int count);
    cdc_pkg::op_t op;
    logic [5:0]   d;
    logic [3:0]   m;
    logic [15:0]  y;
    rx_mode = RX_RANDOM;
    wait_for_results();
    repeat (count) begin
      random_item(op, d, m, y);
      send_item(op, d, m, y);
    end
    wait_for_results();
  endtask

  // Random operations in bursts, with receiver behavior changing per stretch
  task automatic test_random_mix(int count);
    cdc_pkg::op_t op;
    logic [5:0]   d;
    logic [3:0]   m;
    logic [15:0]  y;
    int           burst_left;
    bit           gappy;
    burst_left = 0;
    gappy      = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        rx_mode      = $urandom_range(RX_ALWAYS, RX_PERIODIC);
        rx_ready_pct = $urandom_range(20, 90);
        rx_period    = $urandom_range(2, 7);
        rx_on_cycles = $urandom_range(1, rx_period - 1);
        gappy        = ($urandom_range(0, 3) != 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (gappy) pause_sender($urandom_range(1, 8));
      end
      burst_left--;
      random_item(op, d, m, y);
      send_item(op, d, m, y);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_date();
    test_range_ends();
    test_leap_rollover();
    test_operand_checks();
    test_difference();
    test_backpressure(40);
    test_drain_pause(10);
    test_random_mix(1776);
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
